[hw/rtl/lrbc_pkg.sv]
`default_nettype none

package lrbc_pkg;

  // schedule depth in use and the number of delay registers
  localparam int BACKOFF_STEPS = 5;
  localparam int NUM_DELAYS    = 5;
  localparam int DELAY_IDX_W   = $clog2(NUM_DELAYS);

  localparam int TIME_W    = 32;
  localparam int ATTEMPT_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = '1;
  localparam logic [ATTEMPT_W-1:0] LAST_STEP   = ATTEMPT_W'(BACKOFF_STEPS - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NETWORK_CONFIGURED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECT_TIMEOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_DELAY_0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_DELAY_4    = 3'd6;

  // register reset values
  localparam logic                RST_NETWORK_CONFIGURED = 1'b1;
  localparam logic [TIME_W-1:0]   RST_CONNECT_TIMEOUT    = 32'd15000;
  localparam logic [NUM_DELAYS-1:0][TIME_W-1:0] RST_BACKOFF_DELAY = {
    32'd300000, 32'd120000, 32'd60000, 32'd30000, 32'd10000
  };

  // input opcodes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_CONNECTING = 2'd1,
    MODE_CONNECTED  = 2'd2,
    MODE_BACKOFF    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_CONNECT   = 2'd1,
    ACT_DROP      = 2'd2,
    ACT_RECONNECT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    IND_NONE       = 2'd0,
    IND_CONNECTING = 2'd1,
    IND_CONNECTED  = 2'd2,
    IND_ERROR      = 2'd3
  } indicator_t;

  typedef enum logic [1:0] {
    EVT_NONE = 2'd0,
    EVT_UP   = 2'd1,
    EVT_LOST = 2'd2
  } link_event_t;

  typedef struct packed {
    logic                               network_configured;
    logic [TIME_W-1:0]                  connect_timeout_ms;
    logic [NUM_DELAYS-1:0][TIME_W-1:0]  backoff_delay;
  } cfg_t;

  typedef struct packed {
    mode_t                mode;
    logic [TIME_W-1:0]    phase_start;
    logic [TIME_W-1:0]    wait_ms;
    logic [ATTEMPT_W-1:0] attempt_count;
    logic                 last_link;
  } state_t;

  typedef struct packed {
    logic              opcode;
    logic [TIME_W-1:0] now_ms;
    logic              link_up;
  } item_t;

  typedef struct packed {
    action_t              action;
    indicator_t           indicator;
    mode_t                mode_now;
    link_event_t          link_event;
    logic [ATTEMPT_W-1:0] attempts_now;
    logic [TIME_W-1:0]    current_wait_ms;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/lrbc_in_if.sv]
`default_nettype none

interface lrbc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] now_ms;
  logic        link_up;

  modport source (output valid, output opcode, output now_ms, output link_up, input ready);
  modport sink   (input valid, input opcode, input now_ms, input link_up, output ready);
endinterface

`default_nettype wire

[hw/rtl/lrbc_out_if.sv]
`default_nettype none

interface lrbc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  indicator;
  logic [1:0]  mode_now;
  logic [1:0]  link_event;
  logic [7:0]  attempts_now;
  logic [31:0] current_wait_ms;

  modport source (
    output valid, output action, output indicator, output mode_now,
    output link_event, output attempts_now, output current_wait_ms, input ready
  );
  modport sink (
    input valid, input action, input indicator, input mode_now,
    input link_event, input attempts_now, input current_wait_ms, output ready
  );
endinterface

`default_nettype wire

[hw/rtl/link_reconnect_backoff_controller.sv]
// channel   dir  beat contents
// -------   ---  ---------------------------------------------------------
// req       in   opcode, now_ms, link_up
// rsp       out  action, indicator, mode_now, link_event, attempts_now,
//                current_wait_ms
// cfg       in   cfg_write, cfg_index, cfg_data (write only)
//
// one item per cycle sustained while rsp.ready holds; a result passes the input
// register, then step logic into the result register
// the mode/attempt/timer state updates in the same cycle the result loads
// rst is synchronous; it restores register defaults and idle mode
// a stalled result holds the step; req still takes a beat while the input
// register is empty
`default_nettype none

module link_reconnect_backoff_controller (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lrbc_in_if.sink                              req,
  lrbc_out_if.source                           rsp,
  input  wire logic                            cfg_write,
  input  wire logic [lrbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lrbc_pkg::CFG_DATA_W-1:0] cfg_data
);

  lrbc_pkg::cfg_t    cfg;
  lrbc_pkg::state_t  st;
  lrbc_pkg::state_t  st_next;
  lrbc_pkg::item_t   in_item;
  lrbc_pkg::result_t res;
  lrbc_pkg::result_t res_q;
  logic              in_valid;
  logic              out_valid;
  logic              advance;

  lrbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lrbc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .res     (res)
  );

  // handshake
  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !in_valid || advance;

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      st.mode          <= lrbc_pkg::MODE_IDLE;
      st.phase_start   <= '0;
      st.wait_ms       <= '0;
      st.attempt_count <= '0;
      st.last_link     <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
        if (in_valid) begin
          st <= st_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_item.opcode  <= req.opcode;
      in_item.now_ms  <= req.now_ms;
      in_item.link_up <= req.link_up;
    end
    if (advance && in_valid) begin
      res_q <= res;
    end
  end

  // result beat
  assign rsp.valid           = out_valid;
  assign rsp.action          = res_q.action;
  assign rsp.indicator       = res_q.indicator;
  assign rsp.mode_now        = res_q.mode_now;
  assign rsp.link_event      = res_q.link_event;
  assign rsp.attempts_now    = res_q.attempts_now;
  assign rsp.current_wait_ms = res_q.current_wait_ms;

endmodule

`default_nettype wire

[hw/rtl/lrbc_cfg_regs.sv]
`default_nettype none

module lrbc_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [lrbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lrbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lrbc_pkg::cfg_t                         cfg
);

  logic [lrbc_pkg::DELAY_IDX_W-1:0] delay_idx;

  // delay slot addressed by the index
  assign delay_idx = lrbc_pkg::DELAY_IDX_W'(cfg_index - lrbc_pkg::REG_BACKOFF_DELAY_0);

  // register file, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.network_configured <= lrbc_pkg::RST_NETWORK_CONFIGURED;
      cfg.connect_timeout_ms <= lrbc_pkg::RST_CONNECT_TIMEOUT;
      cfg.backoff_delay      <= lrbc_pkg::RST_BACKOFF_DELAY;
    end else if (cfg_write) begin
      case (cfg_index)
        lrbc_pkg::REG_NETWORK_CONFIGURED: cfg.network_configured <= cfg_data[0];
        lrbc_pkg::REG_CONNECT_TIMEOUT:    cfg.connect_timeout_ms <= cfg_data;
        default: begin
          if (cfg_index inside {[lrbc_pkg::REG_BACKOFF_DELAY_0:lrbc_pkg::REG_BACKOFF_DELAY_4]})
          begin
            cfg.backoff_delay[delay_idx] <= cfg_data;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lrbc_step.sv]
`default_nettype none

module lrbc_step (
  input  wire lrbc_pkg::cfg_t    cfg,
  input  wire lrbc_pkg::state_t  st,
  input  wire lrbc_pkg::item_t   item,
  output lrbc_pkg::state_t       st_next,
  output lrbc_pkg::result_t      res
);

  logic [lrbc_pkg::TIME_W-1:0]      elapsed;
  logic [lrbc_pkg::DELAY_IDX_W-1:0] delay_idx;
  logic                             timed_out;
  logic                             wait_done;

  // wrapping elapsed time since the phase began
  assign elapsed   = item.now_ms - st.phase_start;
  assign timed_out = elapsed > cfg.connect_timeout_ms;
  assign wait_done = elapsed >= st.wait_ms;

  // schedule slot, held on the last step once the schedule runs out
  assign delay_idx = (st.attempt_count > lrbc_pkg::LAST_STEP)
                     ? lrbc_pkg::DELAY_IDX_W'(lrbc_pkg::LAST_STEP)
                     : lrbc_pkg::DELAY_IDX_W'(st.attempt_count);

  always_comb begin
    st_next        = st;
    res.action     = lrbc_pkg::ACT_NONE;
    res.indicator  = lrbc_pkg::IND_NONE;
    res.link_event = lrbc_pkg::EVT_NONE;

    if (item.opcode == lrbc_pkg::OP_BEGIN) begin
      // begin: error without network, else fresh connect attempt
      if (!cfg.network_configured) begin
        res.indicator = lrbc_pkg::IND_ERROR;
      end else begin
        st_next.mode        = lrbc_pkg::MODE_CONNECTING;
        st_next.phase_start = item.now_ms;
        res.action          = lrbc_pkg::ACT_CONNECT;
        res.indicator       = lrbc_pkg::IND_CONNECTING;
      end
    end else begin
      // link edge detection
      if (item.link_up != st.last_link) begin
        st_next.last_link = item.link_up;
        if (item.link_up) begin
          st_next.attempt_count = '0;
          st_next.mode          = lrbc_pkg::MODE_CONNECTED;
          res.indicator         = lrbc_pkg::IND_CONNECTED;
          res.link_event        = lrbc_pkg::EVT_UP;
        end else begin
          res.link_event = lrbc_pkg::EVT_LOST;
        end
      end

      // mode update on the post-edge mode
      case (st_next.mode)
        lrbc_pkg::MODE_CONNECTING: begin
          if (!item.link_up && timed_out) begin
            st_next.wait_ms = cfg.backoff_delay[delay_idx];
            if (st.attempt_count != lrbc_pkg::ATTEMPT_MAX) begin
              st_next.attempt_count = st.attempt_count + 1'b1;
            end
            st_next.mode        = lrbc_pkg::MODE_BACKOFF;
            st_next.phase_start = item.now_ms;
            res.action          = lrbc_pkg::ACT_DROP;
          end
        end
        lrbc_pkg::MODE_CONNECTED: begin
          if (!item.link_up) begin
            st_next.mode        = lrbc_pkg::MODE_CONNECTING;
            st_next.phase_start = item.now_ms;
            res.indicator       = lrbc_pkg::IND_CONNECTING;
            res.action          = lrbc_pkg::ACT_RECONNECT;
          end
        end
        lrbc_pkg::MODE_BACKOFF: begin
          if (wait_done) begin
            st_next.mode        = lrbc_pkg::MODE_CONNECTING;
            st_next.phase_start = item.now_ms;
            res.indicator       = lrbc_pkg::IND_CONNECTING;
            res.action          = lrbc_pkg::ACT_CONNECT;
          end
        end
        default: begin
        end
      endcase
    end

    res.mode_now        = st_next.mode;
    res.attempts_now    = st_next.attempt_count;
    res.current_wait_ms = st_next.wait_ms;
  end

endmodule

`default_nettype wire

[hw/rtl/lrbc_checker.sv]
`default_nettype none

module lrbc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  action,
  input wire logic [1:0]  indicator,
  input wire logic [1:0]  mode_now,
  input wire logic [1:0]  link_event,
  input wire logic [7:0]  attempts_now,
  input wire logic [31:0] current_wait_ms
);

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(action) && $stable(mode_now)
      && $stable(attempts_now) && $stable(current_wait_ms))
    else $error("stalled result changed");

  // no result straight after reset
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a start connect always leaves the block connecting
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && action == lrbc_pkg::ACT_CONNECT |->
      indicator == lrbc_pkg::IND_CONNECTING && mode_now == lrbc_pkg::MODE_CONNECTING)
    else $error("start connect without connecting mode");

  // link up clears the attempt count and enters connected
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && link_event == lrbc_pkg::EVT_UP |->
      mode_now == lrbc_pkg::MODE_CONNECTED && attempts_now == '0)
    else $error("link up without connected mode");

  // a timeout drop always enters backoff with at least one attempt counted
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && action == lrbc_pkg::ACT_DROP |->
      mode_now == lrbc_pkg::MODE_BACKOFF && attempts_now != '0)
    else $error("drop without backoff");

endmodule

bind link_reconnect_backoff_controller lrbc_checker u_lrbc_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .action          (rsp.action),
  .indicator       (rsp.indicator),
  .mode_now        (rsp.mode_now),
  .link_event      (rsp.link_event),
  .attempts_now    (rsp.attempts_now),
  .current_wait_ms (rsp.current_wait_ms)
);

`default_nettype wire

[dv/tb_link_reconnect_backoff_controller.sv]
`timescale 1ns / 1ps

module tb_link_reconnect_backoff_controller;
  import lrbc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int NUM_PHASES  = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  // one line of the directed plan: a register write or a request beat
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [TIME_W-1:0]    data;
    item_t                it;
    bit                   pinned;
    result_t              want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lrbc_in_if  req_if ();
  lrbc_out_if rsp_if ();

  link_reconnect_backoff_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // shadow registers and link state of the predictor
  logic                 m_net;
  logic [TIME_W-1:0]    m_timeout;
  logic [TIME_W-1:0]    m_delay [NUM_DELAYS];
  mode_t                m_mode;
  logic [TIME_W-1:0]    m_start;
  logic [TIME_W-1:0]    m_wait;
  logic [ATTEMPT_W-1:0] m_attempts;
  logic                 m_last;

  result_t awaited_results [$];
  int n_beats, n_checked, n_errors, n_drops, n_err_ind, n_settings, peak_attempts;
  int cycle_count;

  // stimulus knobs shared by the sender and the response side
  bit                tx_on, rx_on;
  int                hold_req;
  logic [TIME_W-1:0] t_now;
  logic              link_drv;
  int step_min, step_max, toggle_pm, begin_pm, noise_pm, jump_pm;

  // mostly short gaps, a few long ones
  function automatic int pick_gap(int longest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, longest);
  endfunction

  // next connection manager result for one request beat
  function automatic result_t predict_link_step(item_t it);
    result_t              r;
    logic [TIME_W-1:0]    elapsed;
    logic [ATTEMPT_W-1:0] slot;
    r.action     = ACT_NONE;
    r.indicator  = IND_NONE;
    r.link_event = EVT_NONE;
    elapsed = it.now_ms - m_start;
    if (it.opcode == OP_BEGIN) begin
      if (!m_net) begin
        r.indicator = IND_ERROR;
      end else begin
        m_mode      = MODE_CONNECTING;
        m_start     = it.now_ms;
        r.action    = ACT_CONNECT;
        r.indicator = IND_CONNECTING;
      end
    end else begin
      // link flag edges
      if (it.link_up != m_last) begin
        m_last = it.link_up;
        if (it.link_up) begin
          m_attempts   = '0;
          m_mode       = MODE_CONNECTED;
          r.indicator  = IND_CONNECTED;
          r.link_event = EVT_UP;
        end else begin
          r.link_event = EVT_LOST;
        end
      end
      case (m_mode)
        MODE_CONNECTING: begin
          if (!it.link_up && elapsed > m_timeout) begin
            slot   = (m_attempts > LAST_STEP) ? LAST_STEP : m_attempts;
            m_wait = m_delay[slot];
            if (m_attempts != ATTEMPT_MAX) m_attempts++;
            m_mode   = MODE_BACKOFF;
            m_start  = it.now_ms;
            r.action = ACT_DROP;
            n_drops++;
          end
        end
        MODE_CONNECTED: begin
          if (!it.link_up) begin
            m_mode      = MODE_CONNECTING;
            m_start     = it.now_ms;
            r.indicator = IND_CONNECTING;
            r.action    = ACT_RECONNECT;
          end
        end
        MODE_BACKOFF: begin
          if (elapsed >= m_wait) begin
            m_mode      = MODE_CONNECTING;
            m_start     = it.now_ms;
            r.indicator = IND_CONNECTING;
            r.action    = ACT_CONNECT;
          end
        end
        default: ;
      endcase
    end
    r.mode_now        = m_mode;
    r.attempts_now    = m_attempts;
    r.current_wait_ms = m_wait;
    if (r.indicator == IND_ERROR) n_err_ind++;
    if (int'(m_attempts) > peak_attempts) peak_attempts = int'(m_attempts);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // compare one result beat with the oldest awaited result
  task automatic check_beat(result_t got);
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing awaited, action %0d mode %0d",
                                got.action, got.mode_now));
      return;
    end
    want = awaited_results.pop_front();
    n_checked++;
    if (got.action !== want.action)
      report_mismatch($sformatf("beat %0d action got %0d want %0d",
                                n_checked, got.action, want.action));
    if (got.indicator !== want.indicator)
      report_mismatch($sformatf("beat %0d indicator got %0d want %0d",
                                n_checked, got.indicator, want.indicator));
    if (got.mode_now !== want.mode_now)
      report_mismatch($sformatf("beat %0d mode_now got %0d want %0d",
                                n_checked, got.mode_now, want.mode_now));
    if (got.link_event !== want.link_event)
      report_mismatch($sformatf("beat %0d link_event got %0d want %0d",
                                n_checked, got.link_event, want.link_event));
    if (got.attempts_now !== want.attempts_now)
      report_mismatch($sformatf("beat %0d attempts_now got %0d want %0d",
                                n_checked, got.attempts_now, want.attempts_now));
    if (got.current_wait_ms !== want.current_wait_ms)
      report_mismatch($sformatf("beat %0d current_wait_ms got %0d want %0d",
                                n_checked, got.current_wait_ms, want.current_wait_ms));
  endtask

  // cycle limit and result monitor
  always @(posedge clk) begin
    result_t got;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, awaited_results.size());
      $display("link_reconnect_backoff_controller regression: fail");
      $finish;
    end else if (rst === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.action          = action_t'(rsp_if.action);
      got.indicator       = indicator_t'(rsp_if.indicator);
      got.mode_now        = mode_t'(rsp_if.mode_now);
      got.link_event      = link_event_t'(rsp_if.link_event);
      got.attempts_now    = rsp_if.attempts_now;
      got.current_wait_ms = rsp_if.current_wait_ms;
      check_beat(got);
    end
  end

  // response side backpressure, with a long hold on request
  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (rx_on) stall_left = pick_gap(60);
      end
    end
  end

  // one request beat, then a random gap when tx_on is set
  task automatic offer(item_t it, bit pinned, result_t want);
    result_t model_r;
    int      gap;
    req_if.valid   <= 1'b1;
    req_if.opcode  <= it.opcode;
    req_if.now_ms  <= it.now_ms;
    req_if.link_up <= it.link_up;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    model_r = predict_link_step(it);
    awaited_results.push_back(pinned ? want : model_r);
    n_beats++;
    @(negedge clk);
    gap = tx_on ? pick_gap(40) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop offering and let every awaited result drain
  task automatic settle();
    req_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_NETWORK_CONFIGURED: m_net = data[0];
      REG_CONNECT_TIMEOUT:    m_timeout = data;
      default: begin
        if (idx >= REG_BACKOFF_DELAY_0 && idx <= REG_BACKOFF_DELAY_4)
          m_delay[idx - REG_BACKOFF_DELAY_0] = data;
      end
    endcase
  endtask

  task automatic load_regs(input logic [TIME_W-1:0] vals [7]);
    for (int i = REG_NETWORK_CONFIGURED; i <= REG_BACKOFF_DELAY_4; i++)
      write_reg(CFG_IDX_W'(i), vals[i]);
    n_settings++;
  endtask

  // directed plan builders
  function automatic row_t item_row(logic op, logic [TIME_W-1:0] t_ms, logic up);
    row_t r;
    r.is_cfg     = 1'b0;
    r.idx        = '0;
    r.data       = '0;
    r.it.opcode  = op;
    r.it.now_ms  = t_ms;
    r.it.link_up = up;
    r.pinned     = 1'b0;
    r.want       = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    row_t r;
    r        = item_row(OP_TICK, '0, 1'b0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic row_t pin(row_t r, action_t a, indicator_t ind, mode_t m,
                               link_event_t e, logic [ATTEMPT_W-1:0] n,
                               logic [TIME_W-1:0] w);
    row_t p;
    p                      = r;
    p.pinned               = 1'b1;
    p.want.action          = a;
    p.want.indicator       = ind;
    p.want.mode_now        = m;
    p.want.link_event      = e;
    p.want.attempts_now    = n;
    p.want.current_wait_ms = w;
    return p;
  endfunction

  // next random request: mostly a coherent timeline, some noise
  function automatic item_t next_request();
    item_t it;
    if ($urandom_range(0, 999) < noise_pm) begin
      it.opcode  = 1'($urandom_range(0, 1));
      it.now_ms  = $urandom();
      it.link_up = 1'($urandom_range(0, 1));
      return it;
    end
    t_now += $urandom_range(step_min, step_max);
    if ($urandom_range(0, 999) < jump_pm) t_now += $urandom();
    if ($urandom_range(0, 999) < toggle_pm) link_drv = ~link_drv;
    if ($urandom_range(0, 999) < begin_pm) begin
      it.opcode  = OP_BEGIN;
      it.link_up = 1'($urandom_range(0, 1));
    end else begin
      it.opcode  = OP_TICK;
      it.link_up = link_drv;
    end
    it.now_ms = t_now;
    return it;
  endfunction

  initial begin
    row_t              plan [$];
    item_t             it;
    result_t           none_r;
    logic [TIME_W-1:0] vals [7];
    int                n;

    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.opcode  = OP_BEGIN;
    req_if.now_ms  = '0;
    req_if.link_up = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hold_req       = 0;
    tx_on          = 1'b1;
    rx_on          = 1'b1;
    t_now          = '0;
    link_drv       = 1'b0;
    none_r         = '0;
    n_settings     = 1;

    // predictor after reset
    m_net      = 1'b1;
    m_timeout  = 32'd15000;
    m_delay[0] = 32'd10000;
    m_delay[1] = 32'd30000;
    m_delay[2] = 32'd60000;
    m_delay[3] = 32'd120000;
    m_delay[4] = 32'd300000;
    m_mode     = MODE_IDLE;
    m_start    = '0;
    m_wait     = '0;
    m_attempts = '0;
    m_last     = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle tick, begin with link flag ignored, timeout boundary
    plan.push_back(pin(item_row(OP_TICK, 32'd0, 1'b0),
                       ACT_NONE, IND_NONE, MODE_IDLE, EVT_NONE, 8'd0, 32'd0));
    plan.push_back(pin(item_row(OP_BEGIN, 32'd100, 1'b1),
                       ACT_CONNECT, IND_CONNECTING, MODE_CONNECTING, EVT_NONE, 8'd0, 32'd0));
    plan.push_back(pin(item_row(OP_TICK, 32'd15100, 1'b0),
                       ACT_NONE, IND_NONE, MODE_CONNECTING, EVT_NONE, 8'd0, 32'd0));
    plan.push_back(pin(item_row(OP_TICK, 32'd15101, 1'b0),
                       ACT_DROP, IND_NONE, MODE_BACKOFF, EVT_NONE, 8'd1, 32'd10000));
    // walk the whole schedule and run past its end
    plan.push_back(item_row(OP_TICK, 32'd25100, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'd25101, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'd40102, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'd70102, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'd85103, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'd145103, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'd160104, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'd280104, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'd295105, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'd595105, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'd610106, 1'b0));
    // link up in backoff, then lost while connected
    plan.push_back(pin(item_row(OP_TICK, 32'd610106, 1'b1),
                       ACT_NONE, IND_CONNECTED, MODE_CONNECTED, EVT_UP, 8'd0, 32'd300000));
    plan.push_back(item_row(OP_TICK, 32'd610200, 1'b1));
    plan.push_back(pin(item_row(OP_TICK, 32'd610300, 1'b0),
                       ACT_RECONNECT, IND_CONNECTING, MODE_CONNECTING, EVT_LOST,
                       8'd0, 32'd300000));
    // time at the top of the range, wrap, begin while connected
    plan.push_back(item_row(OP_TICK, 32'hFFFF_FFFF, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'h0000_0010, 1'b1));
    plan.push_back(item_row(OP_BEGIN, 32'hFFFF_FFFF, 1'b0));
    plan.push_back(item_row(OP_TICK, 32'h0000_3A97, 1'b1));
    // begin without network, write to an unmapped index
    plan.push_back(cfg_row(REG_NETWORK_CONFIGURED, 32'hFFFF_FFFE));
    plan.push_back(pin(item_row(OP_BEGIN, 32'd5, 1'b1),
                       ACT_NONE, IND_ERROR, MODE_CONNECTING, EVT_NONE, 8'd0, 32'd10000));
    plan.push_back(cfg_row(REG_UNMAPPED, 32'hFFFF_FFFF));
    plan.push_back(item_row(OP_BEGIN, 32'd6, 1'b0));
    plan.push_back(cfg_row(REG_NETWORK_CONFIGURED, 32'h0000_0001));
    plan.push_back(item_row(OP_BEGIN, 32'd7, 1'b0));

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        settle();
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        offer(plan[k].it, plan[k].pinned, plan[k].want);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      n         = 200;
      step_min  = 0;
      step_max  = 20;
      toggle_pm = 30;
      begin_pm  = 20;
      noise_pm  = 40;
      jump_pm   = 0;
      tx_on     = (p % 3) != 1;
      rx_on     = (p % 3) != 2;
      case (p)
        0: begin
          // reset values, steps on the scale of the default timers
          n        = 120;
          step_max = 4000;
        end
        1: begin
          vals[0] = 32'd1;
          vals[1] = $urandom_range(0, 40);
          for (int i = 2; i < 7; i++) vals[i] = $urandom_range(0, 60);
          load_regs(vals);
          n = 250;
        end
        2: begin
          // zero timeout and zero delays
          vals[0] = 32'd1;
          for (int i = 1; i < 7; i++) vals[i] = '0;
          load_regs(vals);
          n        = 150;
          step_max = 3;
        end
        3: begin
          // all-ones timeout and delays
          vals[0] = 32'hFFFF_FFFF;
          for (int i = 1; i < 7; i++) vals[i] = 32'hFFFF_FFFF;
          load_regs(vals);
          n        = 150;
          step_max = 1000;
          jump_pm  = 300;
          noise_pm = 150;
        end
        4: begin
          // no network, begins report errors
          vals[0] = $urandom() & 32'hFFFF_FFFE;
          vals[1] = 32'd10;
          for (int i = 2; i < 7; i++) vals[i] = $urandom_range(0, 20);
          load_regs(vals);
          n        = 100;
          begin_pm = 200;
        end
        5: begin
          // timeline across the 32-bit wrap
          vals[0] = $urandom() | 32'h1;
          vals[1] = $urandom_range(0, 60);
          for (int i = 2; i < 7; i++) vals[i] = $urandom_range(0, 100);
          load_regs(vals);
          n     = 180;
          t_now = 32'hFFFF_FF00;
        end
        6: begin
          // link held down with instant timers, drives the attempt count to saturation
          vals[0] = 32'd1;
          for (int i = 1; i < 7; i++) vals[i] = '0;
          load_regs(vals);
          n         = 700;
          step_min  = 1;
          step_max  = 3;
          toggle_pm = 0;
          noise_pm  = 0;
          begin_pm  = 30;
          link_drv  = 1'b0;
        end
        default: begin
          vals[0] = 32'd1;
          vals[1] = $urandom_range(0, 100);
          for (int i = 2; i < 7; i++) begin
            case ($urandom_range(0, 2))
              0:       vals[i] = '0;
              1:       vals[i] = $urandom_range(1, 80);
              default: vals[i] = 32'hFFFF_FFFF;
            endcase
          end
          load_regs(vals);
          n        = 150;
          noise_pm = 300;
        end
      endcase
      for (int i = 0; i < n; i++) begin
        if (p == 1 && i == 40) hold_req = 300;
        if (p == 5 && i == 100) settle();
        it = next_request();
        offer(it, 1'b0, none_r);
      end
    end

    settle();
    repeat (8) @(posedge clk);

    $display("summary: %0d request beats over %0d register settings, %0d results checked",
             n_beats, n_settings, n_checked);
    $display("summary: %0d timeout drops, %0d error indications, attempt count peak %0d",
             n_drops, n_err_ind, peak_attempts);
    if (n_errors == 0) begin
      $display("link_reconnect_backoff_controller regression: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("link_reconnect_backoff_controller regression: fail");
    end
    $finish;
  end

endmodule
